/* rtl/core/bldc_hct_pkg.sv */
`timescale 1ns / 1ps
// Shared types, codes and lookup functions of the hall commutation tracker.
// No dependencies; every other file of the block refers to it by scoped names.

package bldc_hct_pkg;

   localparam int HISTORY_DEPTH = 6;
   localparam int POSITION_BITS = 32;
   localparam int PERIOD_BITS   = 16;
   localparam int PERIOD_MAX    = 65535;
   localparam int SUM_RESET     = PERIOD_MAX * HISTORY_DEPTH;
   localparam int SUM_BITS      = $clog2(SUM_RESET + 1);
   localparam int CMD_BITS      = 11;
   localparam int DUTY_BITS     = 10;
   localparam int DUTY_MAX      = 950;
   localparam int DUTY_MIN      = 1;
   localparam int TIMEOUT_PERIOD = 10000;

   // Request codes.
   localparam logic [1:0] REQ_HALL_EDGE = 2'd0;
   localparam logic [1:0] REQ_TIMEOUT   = 2'd1;
   localparam logic [1:0] REQ_CLEAR     = 2'd2;

   // Bridge leg codes.
   localparam logic [2:0] LEG_ENABLE = 3'd0;
   localparam logic [2:0] LEG_HIGH_Z = 3'd1;
   localparam logic [2:0] LEG_LOW    = 3'd2;
   localparam logic [2:0] LEG_RISE   = 3'd3;
   localparam logic [2:0] LEG_FALL   = 3'd4;
   localparam logic [2:0] LEG_HIGH   = 3'd5;

   typedef struct packed {
      logic [2:0] one;
      logic [2:0] two;
      logic [2:0] three;
   } legs_type;

   typedef struct packed {
      logic       event_en;
      logic       clear_en;
      logic [2:0] hall;
      logic       cw;
   } step_type;

   typedef struct packed {
      legs_type           legs;
      logic signed [31:0] position;
   } comm_result_type;

   typedef struct packed {
      legs_type                legs;
      logic signed [31:0]      rotor_position;
      logic [SUM_BITS-1:0]     six_period_sum;
      logic [PERIOD_BITS-1:0]  newest_period;
      logic [DUTY_BITS-1:0]    target_duty;
      logic                    turn_clockwise;
   } rsp_payload_type;

   function automatic logic [2:0] sector_of_hall(input logic [2:0] hall);
      logic [2:0] sec;
      case (hall)
         3'd0:    sec = 3'd0;
         3'd1:    sec = 3'd1;
         3'd2:    sec = 3'd5;
         3'd3:    sec = 3'd6;
         3'd4:    sec = 3'd3;
         3'd5:    sec = 3'd2;
         3'd6:    sec = 3'd4;
         default: sec = 3'd7;
      endcase
      return sec;
   endfunction

   // Rotating by five steps clockwise or one step otherwise, then mapping
   // back into 1..6; the subtraction of one is folded into the offset.
   function automatic logic [2:0] rotate_sector(input logic [2:0] sec, input logic cw);
      logic [3:0] t;
      t = {1'b0, sec} + (cw ? 4'd4 : 4'd0);
      if (t >= 4'd6) begin
         t = t - 4'd6;
      end
      return t[2:0] + 3'd1;
   endfunction

   function automatic legs_type leg_lookup(input logic [2:0] sec);
      legs_type l;
      case (sec)
         3'd1:    l = '{one: LEG_FALL,   two: LEG_LOW,    three: LEG_ENABLE};
         3'd2:    l = '{one: LEG_LOW,    two: LEG_RISE,   three: LEG_ENABLE};
         3'd3:    l = '{one: LEG_LOW,    two: LEG_ENABLE, three: LEG_FALL};
         3'd4:    l = '{one: LEG_RISE,   two: LEG_ENABLE, three: LEG_LOW};
         3'd5:    l = '{one: LEG_ENABLE, two: LEG_FALL,   three: LEG_LOW};
         3'd6:    l = '{one: LEG_ENABLE, two: LEG_LOW,    three: LEG_RISE};
         default: l = '{one: LEG_HIGH_Z, two: LEG_HIGH_Z, three: LEG_HIGH_Z};
      endcase
      return l;
   endfunction

endpackage

/* rtl/core/bldc_hct_if.sv */
`timescale 1ns / 1ps
// Handshake channels of the hall commutation tracker: request and response.
// Depends on bldc_hct_pkg for widths.

interface bldc_hct_req_if;
   logic                                valid;
   logic                                ready;
   logic [1:0]                          req_type;
   logic [2:0]                          hall_state;
   logic [bldc_hct_pkg::PERIOD_BITS-1:0] captured_period;

   modport source (output valid, req_type, hall_state, captured_period, input ready);
   modport sink   (input valid, req_type, hall_state, captured_period, output ready);
endinterface

interface bldc_hct_rsp_if;
   logic                                valid;
   logic                                ready;
   logic [2:0]                          leg_one_state;
   logic [2:0]                          leg_two_state;
   logic [2:0]                          leg_three_state;
   logic signed [31:0]                  rotor_position;
   logic [bldc_hct_pkg::SUM_BITS-1:0]    six_period_sum;
   logic [bldc_hct_pkg::PERIOD_BITS-1:0] newest_period;
   logic [bldc_hct_pkg::DUTY_BITS-1:0]   target_duty;
   logic                                turn_clockwise;

   modport source (output valid, leg_one_state, leg_two_state, leg_three_state,
                   rotor_position, six_period_sum, newest_period, target_duty,
                   turn_clockwise, input ready);
   modport sink   (input valid, leg_one_state, leg_two_state, leg_three_state,
                   rotor_position, six_period_sum, newest_period, target_duty,
                   turn_clockwise, output ready);
endinterface

/* rtl/core/bldc_hct_cell.sv */
`timescale 1ns / 1ps
// One cell of the period history chain: holds a period, passes it on when
// a beat shifts the chain, and adds its period to the running sum.
// Depends on bldc_hct_pkg.

module bldc_hct_cell (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 shift_en,
   input  logic [bldc_hct_pkg::PERIOD_BITS-1:0] period_in,
   input  logic [bldc_hct_pkg::SUM_BITS-1:0]    sum_in,
   output logic [bldc_hct_pkg::PERIOD_BITS-1:0] period_out,
   output logic [bldc_hct_pkg::SUM_BITS-1:0]    sum_out
);

   logic [bldc_hct_pkg::PERIOD_BITS-1:0] period_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         period_ff <= '0;
      end else if (shift_en) begin
         period_ff <= period_in;
      end
   end

   assign period_out = period_ff;
   assign sum_out    = sum_in + bldc_hct_pkg::SUM_BITS'(period_ff);

endmodule

/* rtl/core/bldc_hct_commutator.sv */
`timescale 1ns / 1ps
// Hall pattern tracking: previous pattern, rotor position and bridge legs.
// Gives the state after the current beat. Depends on bldc_hct_pkg.

module bldc_hct_commutator (
   input  logic                          clock,
   input  logic                          reset,
   input  bldc_hct_pkg::step_type        step,
   output bldc_hct_pkg::comm_result_type result
);

   localparam int PosBits = bldc_hct_pkg::POSITION_BITS;

   logic [2:0]                 prev_hall_ff;
   logic [PosBits-1:0]         position_ff;
   logic [PosBits-1:0]         position_in;
   bldc_hct_pkg::legs_type     legs_ff;
   bldc_hct_pkg::legs_type     legs_in;
   logic [2:0]                 sec_from;
   logic [2:0]                 sec_to;
   logic signed [4:0]          delta_raw;
   logic signed [4:0]          delta;

   assign sec_from  = bldc_hct_pkg::sector_of_hall(prev_hall_ff);
   assign sec_to    = bldc_hct_pkg::sector_of_hall(step.hall);
   assign delta_raw = $signed({2'b00, sec_to}) - $signed({2'b00, sec_from});

   // The shortest way around the six sectors.
   always_comb begin
      if (delta_raw < -5'sd3) begin
         delta = delta_raw + 5'sd6;
      end else if (delta_raw > 5'sd3) begin
         delta = delta_raw - 5'sd6;
      end else begin
         delta = delta_raw;
      end
   end

   always_comb begin
      position_in = position_ff;
      legs_in     = legs_ff;
      if (step.event_en) begin
         position_in = position_ff - PosBits'(delta);
         legs_in     = bldc_hct_pkg::leg_lookup(bldc_hct_pkg::rotate_sector(sec_to, step.cw));
      end else if (step.clear_en) begin
         position_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_hall_ff <= '0;
         position_ff  <= '0;
         legs_ff      <= '{one: bldc_hct_pkg::LEG_LOW, two: bldc_hct_pkg::LEG_LOW,
                           three: bldc_hct_pkg::LEG_LOW};
      end else begin
         if (step.event_en) begin
            prev_hall_ff <= step.hall;
         end
         position_ff <= position_in;
         legs_ff     <= legs_in;
      end
   end

   assign result.legs     = legs_in;
   assign result.position = 32'($signed(position_in));

endmodule

/* rtl/core/bldc_hct_skid.sv */
`timescale 1ns / 1ps
// Two-entry response buffer: an output register and a skid register, so a
// new beat is taken while the previous response still waits. Depends on bldc_hct_pkg.

module bldc_hct_skid (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          push_valid,
   output logic                          push_ready,
   input  bldc_hct_pkg::rsp_payload_type push_data,
   bldc_hct_rsp_if.source                rsp
);

   logic                          out_valid_ff;
   logic                          skid_valid_ff;
   bldc_hct_pkg::rsp_payload_type out_data_ff;
   bldc_hct_pkg::rsp_payload_type skid_data_ff;
   logic                          push;

   assign push_ready = !skid_valid_ff;
   assign push       = push_valid && push_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (!out_valid_ff || rsp.ready) begin
         if (skid_valid_ff) begin
            out_valid_ff  <= 1'b1;
            skid_valid_ff <= 1'b0;
         end else begin
            out_valid_ff <= push;
         end
      end else if (push) begin
         skid_valid_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (!out_valid_ff || rsp.ready) begin
         out_data_ff <= skid_valid_ff ? skid_data_ff : push_data;
      end else if (push) begin
         skid_data_ff <= push_data;
      end
   end

   assign rsp.valid           = out_valid_ff;
   assign rsp.leg_one_state   = out_data_ff.legs.one;
   assign rsp.leg_two_state   = out_data_ff.legs.two;
   assign rsp.leg_three_state = out_data_ff.legs.three;
   assign rsp.rotor_position  = out_data_ff.rotor_position;
   assign rsp.six_period_sum  = out_data_ff.six_period_sum;
   assign rsp.newest_period   = out_data_ff.newest_period;
   assign rsp.target_duty     = out_data_ff.target_duty;
   assign rsp.turn_clockwise  = out_data_ff.turn_clockwise;

endmodule

/* rtl/core/bldc_hall_commutation_tracker_core.sv */
`timescale 1ns / 1ps
// Six-step hall commutation tracker, top level.
// Depends on bldc_hct_pkg, the channel interfaces, cell, commutator and skid.
//
// Usage:
//   The req channel carries one event per beat: a hall edge with its captured
//   period, a hall timeout (period 10000 enters the history) or a clear of the
//   rotor position. The rsp channel returns exactly one beat per request with
//   the bridge leg states, rotor position, the sum of the six periods held
//   before the event, the newest period, and the duty and direction taken
//   from the drive command written through csr_write_enable/csr_write_data.
//   Each response is registered in the output register, or in the skid
//   register while rsp stalls. Throughput is one beat per cycle unless rsp
//   stalls; the period history is a chain of six cells that shifts and
//   sums within the cycle, and the position adder sits in the same cycle.
//   Reset clears the drive command, position, hall memory and history, sets
//   the legs low and the period registers to their idle values, and empties
//   the response buffer.
//   When the receiver stalls, one more request is taken into the skid
//   register; then req.ready drops until the response is drained.

module bldc_hall_commutation_tracker_core (
   input  logic                               clock,
   input  logic                               reset,
   bldc_hct_req_if.sink                       req,
   bldc_hct_rsp_if.source                     rsp,
   input  logic                               csr_write_enable,
   input  logic [bldc_hct_pkg::CMD_BITS-1:0]  csr_write_data
);

   localparam int Depth    = bldc_hct_pkg::HISTORY_DEPTH;
   localparam int PerBits  = bldc_hct_pkg::PERIOD_BITS;
   localparam int SumBits  = bldc_hct_pkg::SUM_BITS;
   localparam int CmdBits  = bldc_hct_pkg::CMD_BITS;
   localparam int DutyBits = bldc_hct_pkg::DUTY_BITS;

   logic [CmdBits-1:0]            drive_command_ff;
   logic [SumBits-1:0]            period_sum_ff;
   logic [PerBits-1:0]            last_period_ff;
   logic                          accept;
   logic                          event_en;
   logic                          push_ready;
   logic [PerBits-1:0]            new_period;
   logic [PerBits-1:0]            hist_period [Depth];
   logic [SumBits-1:0]            sum_chain   [Depth+1];
   logic                          cw;
   logic [CmdBits-1:0]            cmd_mag;
   logic [DutyBits-1:0]           duty;
   bldc_hct_pkg::step_type        step;
   bldc_hct_pkg::comm_result_type comm;
   bldc_hct_pkg::rsp_payload_type result_in;

   assign req.ready = push_ready;
   assign accept    = req.valid && push_ready;
   assign event_en  = accept && (req.req_type == bldc_hct_pkg::REQ_HALL_EDGE ||
                                 req.req_type == bldc_hct_pkg::REQ_TIMEOUT);
   assign new_period = (req.req_type == bldc_hct_pkg::REQ_TIMEOUT) ?
                       PerBits'(bldc_hct_pkg::TIMEOUT_PERIOD) : req.captured_period;

   // Direction and clamped duty from the drive command.
   assign cw      = drive_command_ff[CmdBits-1];
   assign cmd_mag = cw ? (CmdBits'(0) - drive_command_ff) : drive_command_ff;

   always_comb begin
      if (cmd_mag > CmdBits'(bldc_hct_pkg::DUTY_MAX)) begin
         duty = DutyBits'(bldc_hct_pkg::DUTY_MAX);
      end else if (cmd_mag < CmdBits'(bldc_hct_pkg::DUTY_MIN)) begin
         duty = DutyBits'(bldc_hct_pkg::DUTY_MIN);
      end else begin
         duty = cmd_mag[DutyBits-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         drive_command_ff <= '0;
      end else if (csr_write_enable) begin
         drive_command_ff <= csr_write_data;
      end
   end

   // Period history: the running sum passes through all cells before they shift.
   assign sum_chain[0] = '0;

   genvar gi;
   generate
      for (gi = 0; gi < Depth; gi++) begin : g_cell
         bldc_hct_cell u_cell (
            .clock      (clock),
            .reset      (reset),
            .shift_en   (event_en),
            .period_in  ((gi == 0) ? new_period : hist_period[(gi == 0) ? 0 : gi-1]),
            .sum_in     (sum_chain[gi]),
            .period_out (hist_period[gi]),
            .sum_out    (sum_chain[gi+1])
         );
      end
   endgenerate

   always_ff @(posedge clock) begin
      if (reset) begin
         period_sum_ff  <= SumBits'(bldc_hct_pkg::SUM_RESET);
         last_period_ff <= PerBits'(bldc_hct_pkg::PERIOD_MAX);
      end else if (event_en) begin
         period_sum_ff  <= sum_chain[Depth];
         last_period_ff <= new_period;
      end
   end

   assign step.event_en = event_en;
   assign step.clear_en = accept && (req.req_type == bldc_hct_pkg::REQ_CLEAR);
   assign step.hall     = req.hall_state;
   assign step.cw       = cw;

   bldc_hct_commutator u_commutator (
      .clock  (clock),
      .reset  (reset),
      .step   (step),
      .result (comm)
   );

   assign result_in.legs           = comm.legs;
   assign result_in.rotor_position = comm.position;
   assign result_in.six_period_sum = event_en ? sum_chain[Depth] : period_sum_ff;
   assign result_in.newest_period  = event_en ? new_period : last_period_ff;
   assign result_in.target_duty    = duty;
   assign result_in.turn_clockwise = cw;

   bldc_hct_skid u_skid (
      .clock      (clock),
      .reset      (reset),
      .push_valid (req.valid),
      .push_ready (push_ready),
      .push_data  (result_in),
      .rsp        (rsp)
   );

endmodule

/* rtl/core/bldc_hct_checker.sv */
`timescale 1ns / 1ps
// Port-level checks of the hall commutation tracker, bound to the top level.
// Depends on bldc_hct_pkg and the channel interfaces.

module bldc_hct_checker (
   input  logic           clock,
   input  logic           reset,
   bldc_hct_req_if.sink   req,
   bldc_hct_rsp_if.source rsp
);

   // A stalled response keeps its beat.
   assert property (@(posedge clock) disable iff (reset)
      rsp.valid && !rsp.ready |=> rsp.valid && $stable(rsp.rotor_position) &&
                                  $stable(rsp.six_period_sum) && $stable(rsp.newest_period))
      else $error("stalled response changed");

   // Nothing is left in the response buffer after reset.
   assert property (@(posedge clock) reset |=> !rsp.valid)
      else $error("response valid right after reset");

   // The duty is always clamped into its working range.
   assert property (@(posedge clock) disable iff (reset)
      rsp.valid |-> rsp.target_duty >= bldc_hct_pkg::DUTY_BITS'(bldc_hct_pkg::DUTY_MIN) &&
                    rsp.target_duty <= bldc_hct_pkg::DUTY_BITS'(bldc_hct_pkg::DUTY_MAX))
      else $error("target duty out of range");

   // A request is only held off while the response buffer is full, so a
   // response beat is always on offer then. The receiver may already have
   // raised ready again in the cycle in which the skid entry moves out.
   assert property (@(posedge clock) disable iff (reset)
      !req.ready |-> rsp.valid)
      else $error("request stalled with room in the response buffer");

endmodule

bind bldc_hall_commutation_tracker_core bldc_hct_checker u_bldc_hct_checker (
   .clock (clock),
   .reset (reset),
   .req   (req),
   .rsp   (rsp)
);
